// ===== hdl/permutation_code_decoder_assert.svh =====
// Assertion macros for the permutation code decoder.
// PCD_ASSERT_RST checks a property while reset is released.
// PCD_ASSERT_ANY checks a property at every clock edge, reset included.
`ifndef PERMUTATION_CODE_DECODER_ASSERT_SVH
`define PERMUTATION_CODE_DECODER_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define PCD_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define PCD_ASSERT_ANY(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define PCD_ASSERT_RST(lbl, clk, rst_n, prop, msg)

`define PCD_ASSERT_ANY(lbl, clk, prop, msg)

`endif

`endif

// ===== hdl/pcd_pkg.sv =====
`default_nettype none

package pcd_pkg;

  localparam int CAND_W  = 27;
  localparam int WORD_W  = 64;
  localparam int CFG_W   = 64;
  localparam int WLEN_W  = 4;
  localparam int NIB_W   = 4;
  localparam int BYTE_W  = 8;
  localparam int CIDX_W  = 1;
  localparam int MIN_LEN = 3;

  localparam logic [CIDX_W-1:0] REG_WORD_LENGTH  = 1'd0;
  localparam logic [CIDX_W-1:0] REG_LETTER_TABLE = 1'd1;

  typedef logic [NIB_W-1:0] nibble_t;

endpackage

`default_nettype wire

// ===== hdl/pcd_digits.sv =====
`default_nettype none

module pcd_digits import pcd_pkg::*; #(
  parameter int MAX_LETTERS = 8
) (
  input  wire logic [CAND_W-1:0]   number,
  output nibble_t [MAX_LETTERS:0]  quot_nib
);

  // Each quotient floor(number / 10^k) for k >= 1 comes from a constant reciprocal
  // multiply; only its low four bits are needed to recover a digit later.
  localparam int MULT_W = CAND_W + 2;
  localparam int PROD_W = CAND_W + MULT_W + NIB_W;

  assign quot_nib[0] = number[NIB_W-1:0];

  for (genvar k = 1; k <= MAX_LETTERS; k++) begin : g_quot
    localparam logic [63:0] DIVISOR = 64'd10 ** k;
    localparam int          SHIFT   = CAND_W + $clog2(DIVISOR);
    localparam logic [63:0] RECIP   = ((64'd1 << SHIFT) + DIVISOR - 64'd1) / DIVISOR;

    logic [PROD_W-1:0] prod;

    assign prod        = PROD_W'(number) * PROD_W'(RECIP[MULT_W-1:0]);
    assign quot_nib[k] = prod[SHIFT +: NIB_W];
  end

endmodule

`default_nettype wire

// ===== hdl/permutation_code_decoder.sv =====
// Channel   Direction  Handshake            Payload
// in_       input      in_valid/in_ready    in_candidate_number
// out_      output     out_valid/out_ready  out_valid_res, out_permuted_word
// cfg_      input      cfg_we               cfg_index, cfg_data
//
// One transaction is accepted per cycle unless a stall has filled all stages;
// each result passes the input, quotient and result registers in order.
// The constant reciprocal multipliers between the first two registers set the
// clock limit. Reset empties all three stages; no clearing pass is needed.
// A stall holds full stages with no empty stage downstream; empty ones fill.
`default_nettype none

module permutation_code_decoder import pcd_pkg::*; #(
  parameter int MAX_LETTERS = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [CAND_W-1:0] in_candidate_number,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_valid_res,
  output logic [WORD_W-1:0]      out_permuted_word,
  input  wire logic              cfg_we,
  input  wire logic [CIDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data
);

  `include "permutation_code_decoder_assert.svh"

  localparam int LEN_W = $clog2(MAX_LETTERS + 1);
  localparam int IDX_W = $clog2(MAX_LETTERS);

  logic [LEN_W-1:0]  word_length_r;
  logic [WORD_W-1:0] letter_table_r;

  logic                      s1_valid_r;
  logic [CAND_W-1:0]         s1_cand_r;
  logic                      s2_valid_r;
  nibble_t [MAX_LETTERS:0]   s2_nib_r;
  logic                      out_valid_r;
  logic                      out_res_r;
  logic [WORD_W-1:0]         out_word_r;

  nibble_t [MAX_LETTERS:0]   quot_nib;
  nibble_t [MAX_LETTERS-1:0] low_dig;
  nibble_t [MAX_LETTERS-1:0] pos_dig;
  logic [WLEN_W-1:0]         wl_raw;
  logic [LEN_W-1:0]          wl_nxt;
  logic [MAX_LETTERS-1:0]    seen;
  logic [MAX_LETTERS-1:0]    full_mask;
  logic                      in_range;
  logic                      res_nxt;
  logic [WORD_W-1:0]         word_nxt;
  logic                      out_load;
  logic                      s2_load;
  logic                      s1_load;

  assign out_load = !out_valid_r || out_ready;
  assign s2_load  = !s2_valid_r || out_load;
  assign s1_load  = !s1_valid_r || s2_load;
  assign in_ready = s1_load;

  assign wl_raw = cfg_data[WLEN_W-1:0];

  always_comb begin
    priority if (wl_raw < WLEN_W'(MIN_LEN)) begin
      wl_nxt = LEN_W'(MIN_LEN);
    end else if (wl_raw > WLEN_W'(MAX_LETTERS)) begin
      wl_nxt = LEN_W'(MAX_LETTERS);
    end else begin
      wl_nxt = LEN_W'(wl_raw);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_length_r  <= LEN_W'(MIN_LEN);
      letter_table_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WORD_LENGTH:  word_length_r  <= wl_nxt;
        REG_LETTER_TABLE: letter_table_r <= cfg_data;
        default: ;
      endcase
    end
  end

  pcd_digits #(
    .MAX_LETTERS(MAX_LETTERS)
  ) u_digits (
    .number   (s1_cand_r),
    .quot_nib (quot_nib)
  );

  always_comb begin
    for (int j = 0; j < MAX_LETTERS; j++) begin
      low_dig[j] = NIB_W'(s2_nib_r[j] - NIB_W'(s2_nib_r[j+1] * NIB_W'(10)));
    end
    for (int i = 0; i < MAX_LETTERS; i++) begin
      pos_dig[i] = '0;
      for (int len = MIN_LEN; len <= MAX_LETTERS; len++) begin
        if ((word_length_r == LEN_W'(len)) && (i < len)) begin
          pos_dig[i] = low_dig[len-1-i];
        end
      end
    end
    seen      = '0;
    full_mask = '0;
    in_range  = 1'b1;
    for (int i = 0; i < MAX_LETTERS; i++) begin
      if (LEN_W'(i) < word_length_r) begin
        full_mask[i] = 1'b1;
        if (pos_dig[i] >= NIB_W'(word_length_r)) begin
          in_range = 1'b0;
        end else begin
          seen[pos_dig[i][IDX_W-1:0]] = 1'b1;
        end
      end
    end
    res_nxt  = in_range && (seen == full_mask);
    word_nxt = '0;
    if (res_nxt) begin
      for (int i = 0; i < MAX_LETTERS; i++) begin
        if (LEN_W'(i) < word_length_r) begin
          word_nxt[i*BYTE_W +: BYTE_W] =
            letter_table_r[BYTE_W*pos_dig[i][IDX_W-1:0] +: BYTE_W];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_r <= in_valid;
      end
      if (s2_load) begin
        s2_valid_r <= s1_valid_r;
      end
      if (out_load) begin
        out_valid_r <= s2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && in_valid) begin
      s1_cand_r <= in_candidate_number;
    end
    if (s2_load && s1_valid_r) begin
      s2_nib_r <= quot_nib;
    end
    if (out_load && s2_valid_r) begin
      out_res_r  <= res_nxt;
      out_word_r <= word_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_valid_res     = out_res_r;
  assign out_permuted_word = out_word_r;

  `PCD_ASSERT_RST(a_invalid_zero, clk, rst_n,
    (out_valid && !out_valid_res) |-> (out_permuted_word == '0),
    "Rejected candidate produced a non-zero word")

  `PCD_ASSERT_RST(a_upper_bytes_zero, clk, rst_n,
    out_valid |-> ((out_permuted_word >> (BYTE_W * word_length_r)) == '0),
    "Bytes beyond the word length are not zero")

  `PCD_ASSERT_RST(a_full_stall, clk, rst_n,
    (s1_valid_r && s2_valid_r && out_valid_r && !out_ready) |-> !in_ready,
    "Input accepted while every stage is full and the output is stalled")

  `PCD_ASSERT_ANY(a_reset_empty, clk,
    $past(!rst_n) |-> (!out_valid && !s1_valid_r && !s2_valid_r),
    "Pipeline not empty after reset")

endmodule

`default_nettype wire
